### rtl/assert_macros.svh
// Assertion macros shared by the matrix product RTL.
// Each macro expands to one labelled concurrent assertion on a rising clock edge.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("invariant assertion failed");

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication assertion failed");

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle assertion failed");

`endif

### rtl/mm_pkg.sv
// Package for the matrix product engine: widths, command and register codes.
// Also holds the helper functions for dimension clamping, addressing and saturation.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package mm_pkg;

  localparam int MAX_DIM   = 16;
  localparam int IDX_W     = 4;
  localparam int CMD_W     = 2;
  localparam int ELEM_W    = 16;
  localparam int PROD_W    = 36;
  localparam int CFG_W     = 5;
  localparam int CFG_IDX_W = 2;
  localparam int DIM_W     = $clog2(MAX_DIM + 1);
  localparam int ADDR_W    = $clog2(MAX_DIM * MAX_DIM);
  localparam int DEPTH     = MAX_DIM * MAX_DIM;
  localparam int MUL_W     = 2 * ELEM_W;
  localparam int ACC_W     = MUL_W + $clog2(MAX_DIM);
  localparam int SAT_W     = (ACC_W > PROD_W) ? ACC_W : PROD_W;

  localparam logic signed [SAT_W-1:0] PROD_MAX =
    {{(SAT_W - PROD_W + 1){1'b0}}, {(PROD_W - 1){1'b1}}};
  localparam logic signed [SAT_W-1:0] PROD_MIN = ~PROD_MAX;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD_LEFT  = 2'd0,
    CMD_LOAD_RIGHT = 2'd1,
    CMD_COMPUTE    = 2'd2
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEFT_ROWS  = 2'd0,
    REG_INNER_DIM  = 2'd1,
    REG_RIGHT_COLS = 2'd2
  } reg_idx_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (int'(v) > MAX_DIM) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = DIM_W'(v);
    end
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] addr_of(input logic [IDX_W-1:0] r,
                                                input logic [IDX_W-1:0] c);
    return ADDR_W'(int'(r) * MAX_DIM + int'(c));
  endfunction

  function automatic logic signed [PROD_W-1:0] sat_prod(input logic signed [ACC_W-1:0] v);
    logic signed [SAT_W-1:0] w;
    logic signed [PROD_W-1:0] r;
    w = SAT_W'(v);
    if (w > PROD_MAX) begin
      r = PROD_W'(PROD_MAX);
    end else if (w < PROD_MIN) begin
      r = PROD_W'(PROD_MIN);
    end else begin
      r = PROD_W'(w);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/mm_if.sv
// Valid/ready channel interfaces for command transactions and result transactions.
// Depends on mm_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface mm_cmd_if;
  import mm_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         cmd;
  logic [IDX_W-1:0]         row;
  logic [IDX_W-1:0]         col;
  logic signed [ELEM_W-1:0] elem;

  modport source (output valid, cmd, row, col, elem, input ready);
  modport sink   (input valid, cmd, row, col, elem, output ready);
endinterface

interface mm_res_if;
  import mm_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [PROD_W-1:0] prod;
  logic [IDX_W-1:0]         out_col;
  logic                     last;
  logic                     status;

  modport source (output valid, prod, out_col, last, status, input ready);
  modport sink   (input valid, prod, out_col, last, status, output ready);
endinterface

`default_nettype wire

### rtl/matrix_multiply.sv
// Load: its status result is registered in the pending registers, then moved to the output
// register once that is free. Compute: one shared multiply-accumulate pipeline (read,
// multiply, add) is fed inner_dim element pairs per column, then drains and emits the
// column's result. The next command is taken once the last result is registered.
// Reset (synchronous, active high) sets all dimensions to 1 and empties the output register;
// the element stores are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module matrix_multiply (
  input  wire logic                          clk,
  input  wire logic                          rst,
  mm_cmd_if.sink                             cmd_ch,
  mm_res_if.source                           res_ch,
  input  wire logic                          cfg_we,
  input  wire logic [mm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [mm_pkg::CFG_W-1:0]      cfg_wdata
);
  import mm_pkg::*;

  `include "assert_macros.svh"

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_RUN   = 4'b0010,
    S_DRAIN = 4'b0100,
    S_EMIT  = 4'b1000
  } state_t;

  state_t state;

  logic [DIM_W-1:0] left_rows;
  logic [DIM_W-1:0] inner_dim;
  logic [DIM_W-1:0] right_cols;

  logic [IDX_W-1:0] cur_row;
  logic [IDX_W-1:0] k;
  logic [IDX_W-1:0] c;
  logic             computing;

  logic                     v1, v2;
  logic                     lk1, lk2;
  logic signed [MUL_W-1:0]  mul;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  acc_sum;

  logic signed [PROD_W-1:0] pend_prod;
  logic [IDX_W-1:0]         pend_col;
  logic                     pend_last;
  logic                     pend_status;

  logic                     out_valid;
  logic signed [PROD_W-1:0] out_prod;
  logic [IDX_W-1:0]         out_col;
  logic                     out_last;
  logic                     out_status;

  logic             accept;
  logic             out_free;
  logic             ld_left, ld_right, ld_ok;
  logic             k_last;
  logic [ELEM_W-1:0] left_q, right_q;

  assign accept   = cmd_ch.valid && cmd_ch.ready;
  assign out_free = !out_valid || res_ch.ready;
  assign cmd_ch.ready = (state == S_IDLE) && !rst;

  assign ld_left  = (cmd_ch.cmd == CMD_LOAD_LEFT);
  assign ld_right = (cmd_ch.cmd == CMD_LOAD_RIGHT);

  always_comb begin
    if (ld_left) begin
      ld_ok = (DIM_W'(cmd_ch.row) < left_rows) && (DIM_W'(cmd_ch.col) < inner_dim);
    end else begin
      ld_ok = (DIM_W'(cmd_ch.row) < inner_dim) && (DIM_W'(cmd_ch.col) < right_cols);
    end
  end

  assign k_last  = (DIM_W'(k) == inner_dim - DIM_W'(1));
  assign acc_sum = acc + ACC_W'(mul);

  mm_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_left_ram (
    .clk   (clk),
    .we    (accept && ld_left && ld_ok),
    .waddr (addr_of(cmd_ch.row, cmd_ch.col)),
    .wdata (cmd_ch.elem),
    .raddr (addr_of(cur_row, k)),
    .rdata (left_q)
  );

  mm_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_right_ram (
    .clk   (clk),
    .we    (accept && ld_right && ld_ok),
    .waddr (addr_of(cmd_ch.row, cmd_ch.col)),
    .wdata (cmd_ch.elem),
    .raddr (addr_of(k, c)),
    .rdata (right_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      left_rows  <= DIM_W'(1);
      inner_dim  <= DIM_W'(1);
      right_cols <= DIM_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LEFT_ROWS:  left_rows  <= clamp_dim(cfg_wdata);
        REG_INNER_DIM:  inner_dim  <= clamp_dim(cfg_wdata);
        REG_RIGHT_COLS: right_cols <= clamp_dim(cfg_wdata);
        default: ;
      endcase
    end
  end

  // Valid and last-step tracking for the read and multiply stages, and the multiply register, of the shared unit.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= (state == S_RUN);
      v2 <= v1;
    end
    lk1 <= k_last;
    lk2 <= lk1;
    mul <= $signed(left_q) * $signed(right_q);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      computing <= 1'b0;
      k         <= '0;
      c         <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (ld_left || ld_right) begin
              pend_prod   <= '0;
              pend_col    <= '0;
              pend_last   <= 1'b1;
              pend_status <= !ld_ok;
              computing   <= 1'b0;
              state       <= S_EMIT;
            end else if (cmd_ch.cmd == CMD_COMPUTE) begin
              if (DIM_W'(cmd_ch.row) >= left_rows) begin
                pend_prod   <= '0;
                pend_col    <= '0;
                pend_last   <= 1'b1;
                pend_status <= 1'b1;
                computing   <= 1'b0;
                state       <= S_EMIT;
              end else begin
                cur_row   <= cmd_ch.row;
                k         <= '0;
                c         <= '0;
                acc       <= '0;
                computing <= 1'b1;
                state     <= S_RUN;
              end
            end
          end
        end
        S_RUN: begin
          if (k_last) begin
            k     <= '0;
            state <= S_DRAIN;
          end else begin
            k <= k + IDX_W'(1);
          end
        end
        S_DRAIN: begin
          if (v2 && !lk2) begin
            acc <= acc_sum;
          end else if (v2 && lk2) begin
            acc         <= '0;
            pend_prod   <= sat_prod(acc_sum);
            pend_col    <= c;
            pend_last   <= (DIM_W'(c) == right_cols - DIM_W'(1));
            pend_status <= 1'b0;
            state       <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            if (computing && !pend_last) begin
              c     <= c + IDX_W'(1);
              state <= S_RUN;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
      if (state == S_RUN && v2) begin
        acc <= acc_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_EMIT && out_free) begin
      out_valid <= 1'b1;
    end else if (res_ch.ready) begin
      out_valid <= 1'b0;
    end
    if (state == S_EMIT && out_free) begin
      out_prod   <= pend_prod;
      out_col    <= pend_col;
      out_last   <= pend_last;
      out_status <= pend_status;
    end
  end

  assign res_ch.valid   = out_valid;
  assign res_ch.prod    = out_prod;
  assign res_ch.out_col = out_col;
  assign res_ch.last    = out_last;
  assign res_ch.status  = out_status;

  `ASSERT_ALWAYS(a_dims_clamped, clk, rst,
    (left_rows != '0) && (inner_dim != '0) && (right_cols != '0) &&
    (int'(left_rows) <= MAX_DIM) && (int'(inner_dim) <= MAX_DIM) &&
    (int'(right_cols) <= MAX_DIM))
  `ASSERT_IMPL(a_pipe_empty_idle, clk, rst, state == S_IDLE, !v1 && !v2)
  `ASSERT_NEXT(a_emit_fills_output, clk, rst, state == S_EMIT && out_free, out_valid)
  `ASSERT_IMPL(a_error_is_last, clk, rst, out_valid && out_status, out_last && out_prod == '0)

endmodule

`default_nettype wire

### rtl/mm_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module mm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench for the matrix product engine: loads, row computes, range errors, back-pressure.
// Results are predicted at the command handshake and compared in order with the result channel.
// Depends on mm_pkg, the mm_cmd_if and mm_res_if interfaces and the matrix_multiply RTL.
`timescale 1ns / 1ps

module tb_top;
  import mm_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int     LONG_HOLD = 400;
  localparam int     CFG_SETTLE = 16;
  localparam int     END_SETTLE = 320;
  localparam longint PROD_HI = 64'sd34359738367;
  localparam longint PROD_LO = -64'sd34359738368;

  typedef struct {
    logic signed [PROD_W-1:0] prod;
    logic [IDX_W-1:0]         out_col;
    logic                     last;
    logic                     status;
  } result_t;

  typedef struct {
    logic [CMD_W-1:0] op;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } slot_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_wdata;

  mm_cmd_if cmd_bus ();
  mm_res_if res_bus ();

  matrix_multiply u_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_ch    (cmd_bus),
    .res_ch    (res_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  result_t owed_products[$];
  int errors = 0;
  bit idle_on = 1'b1;
  bit long_hold_req = 1'b0;

  int left_rows_eff = 1;
  int inner_eff = 1;
  int right_cols_eff = 1;
  logic signed [ELEM_W-1:0] left_mem [DEPTH];
  logic signed [ELEM_W-1:0] right_mem [DEPTH];
  bit left_set [DEPTH];
  bit right_set [DEPTH];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Timeout: results still outstanding");
    $display("== FAIL ==");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= 40) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
  endtask

  function automatic int dim_from_reg(input logic [CFG_W-1:0] raw);
    if (raw == '0) begin
      return 1;
    end
    if (int'(raw) > MAX_DIM) begin
      return MAX_DIM;
    end
    return int'(raw);
  endfunction

  task automatic predict_matrix_cmd(input logic [CMD_W-1:0] op, input logic [IDX_W-1:0] r,
                                    input logic [IDX_W-1:0] c,
                                    input logic signed [ELEM_W-1:0] v);
    result_t res;
    longint acc;
    int rlim;
    int clim;
    res.prod = '0;
    res.out_col = '0;
    res.last = 1'b1;
    res.status = 1'b0;
    if (op == CMD_LOAD_LEFT || op == CMD_LOAD_RIGHT) begin
      rlim = (op == CMD_LOAD_LEFT) ? left_rows_eff : inner_eff;
      clim = (op == CMD_LOAD_LEFT) ? inner_eff : right_cols_eff;
      if (int'(r) < rlim && int'(c) < clim) begin
        if (op == CMD_LOAD_LEFT) begin
          left_mem[{r, c}] = v;
          left_set[{r, c}] = 1'b1;
        end else begin
          right_mem[{r, c}] = v;
          right_set[{r, c}] = 1'b1;
        end
      end else begin
        res.status = 1'b1;
      end
      owed_products.push_back(res);
    end else if (op == CMD_COMPUTE) begin
      if (int'(r) >= left_rows_eff) begin
        res.status = 1'b1;
        owed_products.push_back(res);
      end else begin
        for (int j = 0; j < right_cols_eff; j++) begin
          acc = 0;
          for (int k = 0; k < inner_eff; k++) begin
            acc += longint'(left_mem[{r, 4'(k)}]) * longint'(right_mem[{4'(k), 4'(j)}]);
          end
          if (acc > PROD_HI) acc = PROD_HI;
          if (acc < PROD_LO) acc = PROD_LO;
          res.prod = acc[PROD_W-1:0];
          res.out_col = 4'(j);
          res.last = (j == right_cols_eff - 1);
          owed_products.push_back(res);
        end
      end
    end
  endtask

  function automatic bit row_ready(input int r);
    for (int k = 0; k < inner_eff; k++) begin
      if (!left_set[{4'(r), 4'(k)}]) return 1'b0;
      for (int c = 0; c < right_cols_eff; c++) begin
        if (!right_set[{4'(k), 4'(c)}]) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic logic signed [ELEM_W-1:0] rand_elem();
    case ($urandom_range(0, 7))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic send_cmd(input logic [CMD_W-1:0] op, input int r, input int c,
                          input logic signed [ELEM_W-1:0] v);
    int gap;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      cmd_bus.valid <= 1'b0;
      gap = $urandom_range(1, 16);
      repeat (gap) @(negedge clk);
    end
    cmd_bus.valid <= 1'b1;
    cmd_bus.cmd <= op;
    cmd_bus.row <= 4'(r);
    cmd_bus.col <= 4'(c);
    cmd_bus.elem <= v;
    @(posedge clk);
    while (cmd_bus.ready !== 1'b1) @(posedge clk);
    predict_matrix_cmd(op, 4'(r), 4'(c), v);
  endtask

  task automatic drain(input int settle);
    @(negedge clk);
    cmd_bus.valid <= 1'b0;
    while (owed_products.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic set_dims(input logic [CFG_W-1:0] rows_raw, input logic [CFG_W-1:0] inner_raw,
                          input logic [CFG_W-1:0] cols_raw);
    drain(CFG_SETTLE);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_LEFT_ROWS;
    cfg_wdata <= rows_raw;
    @(negedge clk);
    cfg_index <= REG_INNER_DIM;
    cfg_wdata <= inner_raw;
    @(negedge clk);
    cfg_index <= REG_RIGHT_COLS;
    cfg_wdata <= cols_raw;
    @(negedge clk);
    cfg_we <= 1'b0;
    left_rows_eff = dim_from_reg(rows_raw);
    inner_eff = dim_from_reg(inner_raw);
    right_cols_eff = dim_from_reg(cols_raw);
  endtask

  // Mostly well-formed traffic: fill the entries a row needs, then compute it; some noise.
  task automatic run_phase(input int n);
    int done;
    int pick;
    int r;
    int k;
    int c;
    logic [CMD_W-1:0] op;
    slot_t gaps[$];
    slot_t s;
    done = 0;
    while (done < n) begin
      pick = $urandom_range(0, 99);
      r = $urandom_range(0, left_rows_eff - 1);
      if (pick < 12) begin
        op = 2'($urandom_range(0, 3));
        r = $urandom_range(0, 15);
        c = $urandom_range(0, 15);
        if (op == CMD_COMPUTE && r < left_rows_eff && !row_ready(r)) op = CMD_LOAD_LEFT;
        send_cmd(op, r, c, rand_elem());
        if (op != CMD_UNUSED) done++;
      end else if (!row_ready(r)) begin
        gaps.delete();
        for (k = 0; k < inner_eff; k++) begin
          if (!left_set[{4'(r), 4'(k)}]) gaps.push_back('{CMD_LOAD_LEFT, 4'(r), 4'(k)});
          for (c = 0; c < right_cols_eff; c++) begin
            if (!right_set[{4'(k), 4'(c)}]) gaps.push_back('{CMD_LOAD_RIGHT, 4'(k), 4'(c)});
          end
        end
        s = gaps[$urandom_range(0, gaps.size() - 1)];
        send_cmd(s.op, s.row, s.col, rand_elem());
        done++;
      end else if (pick < 45) begin
        send_cmd(CMD_COMPUTE, r, $urandom_range(0, 15), rand_elem());
        done++;
      end else if (pick < 72) begin
        send_cmd(CMD_LOAD_LEFT, r, $urandom_range(0, inner_eff - 1), rand_elem());
        done++;
      end else begin
        send_cmd(CMD_LOAD_RIGHT, $urandom_range(0, inner_eff - 1),
                 $urandom_range(0, right_cols_eff - 1), rand_elem());
        done++;
      end
    end
  endtask

  task automatic test_edge_values();
    send_cmd(CMD_LOAD_LEFT, 0, 0, 16'sh8000);
    send_cmd(CMD_LOAD_RIGHT, 0, 0, 16'sh8000);
    send_cmd(CMD_COMPUTE, 0, 15, 16'shffff);
    send_cmd(CMD_LOAD_LEFT, 1, 0, 16'sh1234);
    send_cmd(CMD_LOAD_LEFT, 0, 1, 16'sh1234);
    send_cmd(CMD_LOAD_RIGHT, 1, 0, 16'sh4321);
    send_cmd(CMD_LOAD_RIGHT, 0, 1, 16'sh4321);
    send_cmd(CMD_LOAD_LEFT, 15, 15, 16'shffff);
    send_cmd(CMD_COMPUTE, 15, 0, 16'sh0000);
    send_cmd(CMD_COMPUTE, 1, 0, 16'sh0000);
    send_cmd(CMD_UNUSED, 15, 15, 16'shffff);
    send_cmd(CMD_LOAD_LEFT, 0, 0, 16'sh7fff);
    send_cmd(CMD_COMPUTE, 0, 0, 16'sh0000);
    send_cmd(CMD_LOAD_RIGHT, 0, 0, 16'sh0001);
    send_cmd(CMD_COMPUTE, 0, 0, 16'sh0000);
  endtask

  task automatic test_register_limits();
    set_dims(5'd0, 5'd0, 5'd0);
    send_cmd(CMD_LOAD_LEFT, 0, 1, 16'sh0100);
    send_cmd(CMD_COMPUTE, 0, 0, 16'sh0000);
    set_dims(5'd31, 5'd31, 5'd31);
    send_cmd(CMD_LOAD_LEFT, 15, 15, 16'sh7fff);
    send_cmd(CMD_LOAD_RIGHT, 15, 15, 16'sh8000);
    set_dims(5'd16, 5'd16, 5'd16);
    send_cmd(CMD_LOAD_RIGHT, 15, 0, 16'sh0080);
    set_dims(5'd17, 5'd1, 5'd1);
    send_cmd(CMD_LOAD_LEFT, 15, 0, 16'shff00);
    send_cmd(CMD_COMPUTE, 15, 0, 16'sh0000);
  endtask

  task automatic test_random_mix();
    set_dims(5'd1, 5'd16, 5'd1);
    run_phase(50);
    set_dims(5'd2, 5'd1, 5'd16);
    run_phase(36);
    set_dims(5'd20, 5'd1, 5'd1);
    run_phase(32);
    set_dims(5'd3, 5'd3, 5'd3);
    run_phase(32);
    repeat (3) begin
      set_dims(5'($urandom_range(1, 5)), 5'($urandom_range(1, 5)), 5'($urandom_range(1, 5)));
      run_phase(30);
    end
  endtask

  task automatic test_backpressure();
    set_dims(5'd2, 5'd2, 5'd4);
    long_hold_req = 1'b1;
    run_phase(30);
  endtask

  task automatic test_no_idle();
    idle_on = 1'b0;
    set_dims(5'($urandom_range(1, 4)), 5'($urandom_range(1, 4)), 5'($urandom_range(1, 6)));
    run_phase(30);
  endtask

  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    res_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        res_bus.ready <= 1'b0;
        hold_left--;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = LONG_HOLD - 1;
        res_bus.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        hold_left = $urandom_range(0, 15);
        res_bus.ready <= 1'b0;
      end else begin
        res_bus.ready <= 1'b1;
      end
    end
  end

  initial begin : result_check
    result_t want;
    forever begin
      @(posedge clk);
      if (rst === 1'b0 && res_bus.valid === 1'b1 && res_bus.ready === 1'b1) begin
        if (owed_products.size() == 0) begin
          report_mismatch("result transaction with nothing outstanding");
        end else begin
          want = owed_products.pop_front();
          if (res_bus.prod !== want.prod)
            report_mismatch($sformatf("prod %0d, wanted %0d", res_bus.prod, want.prod));
          if (res_bus.out_col !== want.out_col)
            report_mismatch($sformatf("out_col %0d, wanted %0d", res_bus.out_col,
                                      want.out_col));
          if (res_bus.last !== want.last)
            report_mismatch($sformatf("last %b, wanted %b", res_bus.last, want.last));
          if (res_bus.status !== want.status)
            report_mismatch($sformatf("status %b, wanted %b", res_bus.status, want.status));
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_LEFT_ROWS;
    cfg_wdata = '0;
    cmd_bus.valid = 1'b0;
    cmd_bus.cmd = CMD_LOAD_LEFT;
    cmd_bus.row = '0;
    cmd_bus.col = '0;
    cmd_bus.elem = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_edge_values();
    test_register_limits();
    test_random_mix();
    test_backpressure();
    test_no_idle();
    drain(END_SETTLE);

    if (owed_products.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", owed_products.size()));
    end
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
